>>> rtl/tspd_pkg.sv
`default_nettype none
package tspd_pkg;

	// frame and error history lengths
	localparam int FRAME_BITS  = 59;
	localparam int ERROR_HOLD  = 43;
	localparam int OUT_FRAME_W = 59;

	localparam int TS_W        = 32;
	localparam int WIN_W       = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 64;
	localparam int APB_AW      = 5;
	localparam int APB_DW      = 32;

	// window bounds after reset, in milliseconds
	localparam logic [WIN_W-1:0] RST_SEC_MIN  = 16'd900;
	localparam logic [WIN_W-1:0] RST_SEC_MAX  = 16'd1100;
	localparam logic [WIN_W-1:0] RST_MIN_MIN  = 16'd1900;
	localparam logic [WIN_W-1:0] RST_MIN_MAX  = 16'd2100;
	localparam logic [WIN_W-1:0] RST_ZERO_MIN = 16'd60;
	localparam logic [WIN_W-1:0] RST_ZERO_MAX = 16'd140;
	localparam logic [WIN_W-1:0] RST_ONE_MIN  = 16'd160;
	localparam logic [WIN_W-1:0] RST_ONE_MAX  = 16'd240;

	typedef enum logic [2:0] {
		REG_SEC_MIN,
		REG_SEC_MAX,
		REG_MIN_MIN,
		REG_MIN_MAX,
		REG_ZERO_MIN,
		REG_ZERO_MAX,
		REG_ONE_MIN,
		REG_ONE_MAX
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_BUSY,
		ST_READY,
		ST_REJECT,
		ST_POWER_FAIL
	} status_t;

	typedef struct packed {
		logic [WIN_W-1:0] sec_min;
		logic [WIN_W-1:0] sec_max;
		logic [WIN_W-1:0] min_min;
		logic [WIN_W-1:0] min_max;
		logic [WIN_W-1:0] zero_min;
		logic [WIN_W-1:0] zero_max;
		logic [WIN_W-1:0] one_min;
		logic [WIN_W-1:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic            power_good;
		logic [TS_W-1:0] timestamp_ms;
		logic            carrier_level;
	} item_t;

	typedef struct packed {
		logic                   indicator_level;
		logic                   timing_error;
		logic [OUT_FRAME_W-1:0] frame_bits;
		status_t                status;
	} res_t;

	// exclusive window test
	function automatic logic in_win(logic [TS_W-1:0] d, logic [WIN_W-1:0] lo,
			logic [WIN_W-1:0] hi);
		return (d > {{(TS_W-WIN_W){1'b0}}, lo}) && (d < {{(TS_W-WIN_W){1'b0}}, hi});
	endfunction

endpackage
`default_nettype wire

>>> rtl/tspd_cfg_regs.sv
`default_nettype none
module tspd_cfg_regs
	import tspd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sec_min  <= RST_SEC_MIN;
			cfg_q.sec_max  <= RST_SEC_MAX;
			cfg_q.min_min  <= RST_MIN_MIN;
			cfg_q.min_max  <= RST_MIN_MAX;
			cfg_q.zero_min <= RST_ZERO_MIN;
			cfg_q.zero_max <= RST_ZERO_MAX;
			cfg_q.one_min  <= RST_ONE_MIN;
			cfg_q.one_max  <= RST_ONE_MAX;
		end else if (wr_en) begin
			case (idx)
				REG_SEC_MIN:  cfg_q.sec_min  <= pwdata[WIN_W-1:0];
				REG_SEC_MAX:  cfg_q.sec_max  <= pwdata[WIN_W-1:0];
				REG_MIN_MIN:  cfg_q.min_min  <= pwdata[WIN_W-1:0];
				REG_MIN_MAX:  cfg_q.min_max  <= pwdata[WIN_W-1:0];
				REG_ZERO_MIN: cfg_q.zero_min <= pwdata[WIN_W-1:0];
				REG_ZERO_MAX: cfg_q.zero_max <= pwdata[WIN_W-1:0];
				REG_ONE_MIN:  cfg_q.one_min  <= pwdata[WIN_W-1:0];
				REG_ONE_MAX:  cfg_q.one_max  <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SEC_MIN:  prdata[WIN_W-1:0] = cfg_q.sec_min;
			REG_SEC_MAX:  prdata[WIN_W-1:0] = cfg_q.sec_max;
			REG_MIN_MIN:  prdata[WIN_W-1:0] = cfg_q.min_min;
			REG_MIN_MAX:  prdata[WIN_W-1:0] = cfg_q.min_max;
			REG_ZERO_MIN: prdata[WIN_W-1:0] = cfg_q.zero_min;
			REG_ZERO_MAX: prdata[WIN_W-1:0] = cfg_q.zero_max;
			REG_ONE_MIN:  prdata[WIN_W-1:0] = cfg_q.one_min;
			REG_ONE_MAX:  prdata[WIN_W-1:0] = cfg_q.one_max;
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/tspd_core.sv
`default_nettype none
module tspd_core
	import tspd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output res_t      res
);

	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [ERROR_HOLD-1:0] hist_q, hist_d;
	logic [TS_W-1:0]       rise_q, rise_d;
	logic                  level_q, level_d;
	logic [TS_W-1:0]       dur;
	logic [ERROR_HOLD-1:0] hist_sh;

	assign dur     = item.timestamp_ms - rise_q;
	assign hist_sh = hist_q >> 1;

	always_comb begin
		frame_d = frame_q;
		hist_d  = hist_q;
		rise_d  = rise_q;
		level_d = level_q;
		res.status       = ST_BUSY;
		res.frame_bits   = '0;
		res.timing_error = 1'b0;
		if (!item.power_good) begin
			res.status = ST_POWER_FAIL;
		end else if (item.carrier_level != level_q) begin
			level_d = item.carrier_level;
			if (item.carrier_level) begin
				// rising edge: classify gap since previous rise
				hist_d = hist_sh;
				rise_d = item.timestamp_ms;
				if (in_win(dur, cfg.sec_min, cfg.sec_max)) begin
					hist_d = hist_sh;
				end else if (in_win(dur, cfg.min_min, cfg.min_max)) begin
					res.status     = (hist_sh == '0) ? ST_READY : ST_REJECT;
					res.frame_bits = frame_q[OUT_FRAME_W-1:0];
					frame_d        = '0;
				end else begin
					hist_d[ERROR_HOLD-1] = 1'b1;
					res.timing_error     = 1'b1;
				end
			end else begin
				// falling edge: pulse width gives the bit
				if (in_win(dur, cfg.zero_min, cfg.zero_max)) begin
					frame_d = {1'b0, frame_q[FRAME_BITS-1:1]};
				end else if (in_win(dur, cfg.one_min, cfg.one_max)) begin
					frame_d = {1'b1, frame_q[FRAME_BITS-1:1]};
				end else begin
					frame_d              = {1'b0, frame_q[FRAME_BITS-1:1]};
					hist_d[ERROR_HOLD-1] = 1'b1;
					res.timing_error     = 1'b1;
				end
			end
		end
		res.indicator_level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			hist_q  <= '0;
			rise_q  <= '0;
			level_q <= 1'b0;
		end else if (step) begin
			frame_q <= frame_d;
			hist_q  <= hist_d;
			rise_q  <= rise_d;
			level_q <= level_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/time_signal_pulse_decoder_unit.sv
`default_nettype none
// path from input transfer to result valid: input register, then result register
// throughput: one item per cycle while m_tready is high; the decode state updates in the same cycle the
// result register loads, so the next sample already sees it
// reset: arst_n asynchronous, active low; clears valids, decode state and restores
// the default timing windows
module time_signal_pulse_decoder_unit
	import tspd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [0] carrier_level, [32:1] timestamp_ms, [33] power_good, [39:34] unused
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [1:0] status, [60:2] frame_bits, [61] timing_error, [62] indicator_level, [63] zero
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	// configuration port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_AW-1:0]      paddr,
	input  wire logic [APB_DW-1:0]      pwdata,
	output logic      [APB_DW-1:0]      prdata,
	output logic                        pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	res_t  res_s2;
	logic  vld_s2;
	res_t  res;
	logic  adv;

	// timing window registers
	tspd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// item moves from input register to result register when the result slot
	// is empty or being drained in this cycle
	assign adv      = vld_s1 & (~vld_s2 | m_tready);
	assign s_tready = ~vld_s1 | adv;

	// edge detection, gap and width decoding, frame and history update
	tspd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_TDATA_W-$bits(res_t)){1'b0}}, res_s2};

`ifndef NO_ASSERTIONS
	// a frame only goes out on a matched minute mark, never with an error flag
	a_frame_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (res_s2.status == ST_READY || res_s2.status == ST_REJECT)
		|-> !res_s2.timing_error)
		else $error("frame result carries timing error");

	// power failure and busy results carry no frame
	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (res_s2.status == ST_BUSY || res_s2.status == ST_POWER_FAIL)
		|-> (res_s2.frame_bits == '0))
		else $error("frame bits set without a minute mark");

	// a stalled result holds the waiting item in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !m_tready |=> vld_s1 && $stable(item_s1))
		else $error("input item lost during stall");
`endif

endmodule
`default_nettype wire
